// File: design/lcpf_pkg.sv
// Package for the LED command packet framer: kind codes, job descriptor type,
// packet constants, and the byte-selection helpers used by the back end.
// No dependencies.
package lcpf_pkg;

  // Number of LEDs in one frame packet.
  localparam int unsigned LED_COUNT = 64;
  // Packet bytes carried by one report after its report-id byte.
  localparam int unsigned DATA_PER_REPORT = 64;

  // Input kind codes.
  localparam logic [1:0] KIND_HDR = 2'd0;
  localparam logic [1:0] KIND_PAY = 2'd1;
  localparam logic [1:0] KIND_LED = 2'd2;

  // Fixed packet bytes.
  localparam logic [7:0] CHAR_R      = 8'h52;
  localparam logic [7:0] CHAR_B      = 8'h42;
  localparam logic [7:0] CHAR_S      = 8'h53;
  localparam logic [7:0] CHAR_C      = 8'h43;
  localparam logic [7:0] FRAME_FLAG  = 8'd128;
  localparam logic [7:0] CMD_EXTRA   = 8'd6;
  localparam logic [15:0] FRAME_LEN  = 16'(5 * LED_COUNT + 7);
  localparam logic [7:0] LED_LAST    = 8'(LED_COUNT);

  // Work passed from the front to the back.
  typedef enum logic [2:0] {
    JOB_MIS   = 3'd0,
    JOB_CMD   = 3'd1,
    JOB_PAY   = 3'd2,
    JOB_FRAME = 3'd3,
    JOB_LED   = 3'd4
  } job_e;

  typedef struct packed {
    job_e       op;
    logic [7:0] data;   // action, payload byte or red
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] count;  // payload count of a command header
    logic [7:0] mid;    // message id of a header
    logic [7:0] n;      // 1-based LED number
    logic       csum;   // the job closes the packet with its checksum
  } job_t;

  // Number of packet bytes a job emits, checksum included.
  function automatic logic [3:0] job_len(input job_t job);
    logic [3:0] len;
    case (job.op)
      JOB_CMD:   len = 4'd5;
      JOB_PAY:   len = 4'd1;
      JOB_FRAME: len = 4'd11;
      JOB_LED:   len = 4'd5;
      default:   len = 4'd1;
    endcase
    return len + 4'(job.csum);
  endfunction

  // LED group bytes: n, r, g, b, n.
  function automatic logic [7:0] led_byte(input job_t job, input logic [3:0] idx);
    logic [7:0] b;
    case (idx)
      4'd1:    b = job.data;
      4'd2:    b = job.green;
      4'd3:    b = job.blue;
      default: b = job.n;
    endcase
    return b;
  endfunction

  // Packet byte at position step of a job (checksum handled by the caller).
  function automatic logic [7:0] job_byte(input job_t job, input logic [3:0] step);
    logic [7:0] b;
    b = 8'd0;
    case (job.op)
      JOB_CMD: begin
        case (step)
          4'd0:    b = CHAR_R;
          4'd1:    b = CHAR_B;
          4'd2:    b = job.count + CMD_EXTRA;
          4'd3:    b = job.mid;
          default: b = job.data;
        endcase
      end
      JOB_PAY: b = job.data;
      JOB_FRAME: begin
        case (step)
          4'd0:    b = CHAR_S;
          4'd1:    b = CHAR_C;
          4'd2:    b = FRAME_LEN[15:8];
          4'd3:    b = FRAME_LEN[7:0];
          4'd4:    b = job.mid;
          4'd5:    b = FRAME_FLAG;
          default: b = led_byte(job, step - 4'd6);
        endcase
      end
      JOB_LED: b = led_byte(job, step);
      default: b = 8'd0;
    endcase
    return b;
  endfunction

endpackage

// File: design/led_command_packet_framer.sv
// LED command packet framer. Each accepted word (command header, command
// payload byte or LED colour) becomes a job in a two-entry queue; the back end
// emits one output word per cycle while it has a job and the output is not
// stalled, and the words cause these numbers of results: a command header 6
// or 7, a payload byte 1 to 3, an LED 5 to 7, a frame's first LED 12, and a
// dropped out-of-order word 1. The front accepts a new word every cycle while
// the queue has room, also while a result waits on the output.
// Depends on lcpf_pkg, lcpf_front, lcpf_queue and lcpf_back.
module led_command_packet_framer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] kind_i,
  input  logic [7:0] action_i,
  input  logic [7:0] payload_count_i,
  input  logic [7:0] data_byte_i,
  input  logic [7:0] red_i,
  input  logic [7:0] green_i,
  input  logic [7:0] blue_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       is_report_id_o,
  output logic       packet_end_o,
  output logic [5:0] pad_zeros_o,
  output logic       misordered_o,
  output logic       last_o
);
  import lcpf_pkg::*;

  logic push, pop, q_full, q_empty;
  job_t job_in, job_out;

  // Order checking and job building.
  lcpf_front u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .kind_i,
    .action_i,
    .payload_count_i,
    .data_byte_i,
    .red_i,
    .green_i,
    .blue_i,
    .q_full_i (q_full),
    .push_o   (push),
    .job_o    (job_in)
  );

  // Decoupling queue.
  lcpf_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i  (push),
    .job_i   (job_in),
    .full_o  (q_full),
    .pop_i   (pop),
    .empty_o (q_empty),
    .job_o   (job_out)
  );

  // Byte sequencing and report framing.
  lcpf_back u_back (
    .clk_i,
    .rst_ni,
    .q_empty_i (q_empty),
    .job_i     (job_out),
    .pop_o     (pop),
    .out_valid_o,
    .out_ready_i,
    .out_byte_o,
    .is_report_id_o,
    .packet_end_o,
    .pad_zeros_o,
    .misordered_o,
    .last_o
  );

endmodule

// File: design/lcpf_front.sv
// Front end of the framer: accepts input words, checks their order against
// the packet phase and turns each into a job descriptor. Uses lcpf_pkg.
module lcpf_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        kind_i,
  input  logic [7:0]        action_i,
  input  logic [7:0]        payload_count_i,
  input  logic [7:0]        data_byte_i,
  input  logic [7:0]        red_i,
  input  logic [7:0]        green_i,
  input  logic [7:0]        blue_i,
  input  logic              q_full_i,
  output logic              push_o,
  output lcpf_pkg::job_t    job_o
);
  import lcpf_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'b001,
    PH_CMD   = 3'b010,
    PH_FRAME = 3'b100
  } phase_e;

  phase_e     phase_q, phase_d;
  logic [7:0] mid_q, mid_d;
  logic [7:0] left_q, left_d;
  logic [7:0] led_q, led_d;
  logic [7:0] n_next;
  job_t       job;

  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i;
  assign n_next     = led_q + 8'd1;

  // Classify the word and work out the next packet phase.
  always_comb begin
    job       = '0;
    job.op    = JOB_MIS;
    job.green = green_i;
    job.blue  = blue_i;
    job.count = payload_count_i;
    job.mid   = mid_q;
    phase_d   = phase_q;
    mid_d     = mid_q;
    left_d    = left_q;
    led_d     = led_q;
    case (phase_q)
      PH_IDLE: begin
        if (kind_i == KIND_HDR) begin
          job.op   = JOB_CMD;
          job.data = action_i;
          job.csum = (payload_count_i == 8'd0);
          mid_d    = mid_q + 8'd1;
          left_d   = payload_count_i;
          phase_d  = job.csum ? PH_IDLE : PH_CMD;
        end else if (kind_i == KIND_LED) begin
          job.op   = JOB_FRAME;
          job.data = red_i;
          job.n    = 8'd1;
          job.csum = (8'd1 >= LED_LAST);
          mid_d    = mid_q + 8'd1;
          led_d    = 8'd1;
          phase_d  = job.csum ? PH_IDLE : PH_FRAME;
        end
      end
      PH_CMD: begin
        if (kind_i == KIND_PAY) begin
          job.op   = JOB_PAY;
          job.data = data_byte_i;
          job.csum = (left_q == 8'd1);
          left_d   = left_q - 8'd1;
          phase_d  = job.csum ? PH_IDLE : PH_CMD;
        end
      end
      PH_FRAME: begin
        if (kind_i == KIND_LED) begin
          job.op   = JOB_LED;
          job.data = red_i;
          job.n    = n_next;
          job.csum = (n_next >= LED_LAST);
          led_d    = n_next;
          phase_d  = job.csum ? PH_IDLE : PH_FRAME;
        end
      end
      default: phase_d = PH_IDLE;
    endcase
  end

  assign job_o = job;

  // Packet state advances only on an accepted word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      mid_q   <= 8'd0;
      left_q  <= 8'd0;
      led_q   <= 8'd0;
    end else if (push_o) begin
      phase_q <= phase_d;
      mid_q   <= mid_d;
      left_q  <= left_d;
      led_q   <= led_d;
    end
  end

endmodule

// File: design/lcpf_queue.sv
// Two-entry job queue between the front and the back of the framer.
// Uses lcpf_pkg for the job descriptor.
module lcpf_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  lcpf_pkg::job_t  job_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output lcpf_pkg::job_t  job_o
);
  import lcpf_pkg::*;

  job_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign job_o   = mem_q[rd_ptr_q];

  // Storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  // The queue is never written full or read empty.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("job queue written while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o))
    else $error("job queue read while empty");
  // The fill count never exceeds the two entries.
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'd2)
    else $error("job queue fill count out of range");

endmodule

// File: design/lcpf_back.sv
// Back end of the framer: expands jobs into packet bytes, inserts report-id
// bytes, keeps the checksum and report fill, and drives the output register.
// Uses lcpf_pkg.
module lcpf_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_empty_i,
  input  lcpf_pkg::job_t  job_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [7:0]      out_byte_o,
  output logic            is_report_id_o,
  output logic            packet_end_o,
  output logic [5:0]      pad_zeros_o,
  output logic            misordered_o,
  output logic            last_o
);
  import lcpf_pkg::*;

  logic [3:0] step_q, step_d;
  logic       rid_done_q, rid_done_d;
  logic [7:0] sum_q, sum_d;
  logic [5:0] fill_q, fill_d;
  logic       out_valid_q;
  logic [7:0] byte_q, byte_d;
  logic       rid_q, rid_d;
  logic       end_q, end_d;
  logic [5:0] pad_q, pad_d;
  logic       mis_q, mis_d;
  logic       last_q, last_d;

  logic       emit;
  logic [3:0] len;
  logic       last_step;
  logic       is_csum;
  logic [5:0] fill_inc;
  logic [7:0] pkt_byte;

  assign emit      = !q_empty_i && (!out_valid_q || out_ready_i);
  assign len       = job_len(job_i);
  assign last_step = (step_q == len - 4'd1);
  assign is_csum   = job_i.csum && last_step;
  assign fill_inc  = fill_q + 6'd1;
  assign pkt_byte  = job_byte(job_i, step_q);

  // One result per cycle while a job waits and the output is not stalled: a dropped word, a report id or a packet byte.
  always_comb begin
    step_d     = step_q;
    rid_done_d = rid_done_q;
    sum_d      = sum_q;
    fill_d     = fill_q;
    byte_d     = 8'd0;
    rid_d      = 1'b0;
    end_d      = 1'b0;
    pad_d      = 6'd0;
    mis_d      = 1'b0;
    last_d     = 1'b0;
    pop_o      = 1'b0;
    if (job_i.op == JOB_MIS) begin
      mis_d  = 1'b1;
      last_d = 1'b1;
      pop_o  = emit;
    end else if (fill_q == 6'd0 && !rid_done_q) begin
      rid_d      = 1'b1;
      rid_done_d = 1'b1;
    end else begin
      rid_done_d = 1'b0;
      last_d     = last_step;
      pop_o      = emit && last_step;
      step_d     = last_step ? 4'd0 : step_q + 4'd1;
      if (is_csum) begin
        byte_d = sum_q;
        end_d  = 1'b1;
        pad_d  = 6'd0 - fill_inc;
        sum_d  = 8'd0;
        fill_d = 6'd0;
      end else begin
        byte_d = pkt_byte;
        sum_d  = sum_q + pkt_byte;
        fill_d = fill_inc;
      end
    end
  end

  // Sequencer state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= 4'd0;
      rid_done_q  <= 1'b0;
      sum_q       <= 8'd0;
      fill_q      <= 6'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (emit) begin
        step_q     <= step_d;
        rid_done_q <= rid_done_d;
        sum_q      <= sum_d;
        fill_q     <= fill_d;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output word register.
  always_ff @(posedge clk_i) begin
    if (emit) begin
      byte_q <= byte_d;
      rid_q  <= rid_d;
      end_q  <= end_d;
      pad_q  <= pad_d;
      mis_q  <= mis_d;
      last_q <= last_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_byte_o     = byte_q;
  assign is_report_id_o = rid_q;
  assign packet_end_o   = end_q;
  assign pad_zeros_o    = pad_q;
  assign misordered_o   = mis_q;
  assign last_o         = last_q;

  // A checksum always closes the word's results, a report id never does.
  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && end_q |-> last_q)
    else $error("checksum word not marked last");
  a_rid_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && rid_q |-> !last_q && !end_q)
    else $error("report id word marked last or end");
  // After a checksum the next packet starts a fresh report.
  a_fresh_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && is_csum && job_i.op != JOB_MIS && !(fill_q == 6'd0 && !rid_done_q)
    |=> fill_q == 6'd0 && sum_q == 8'd0)
    else $error("report fill not cleared after checksum");

endmodule
